// ===== rtl/hbct_pkg.sv =====
// ---------------------------------------------------------------------------
// hbct_pkg: shared types and constants
// field widths, hash constants and the per-record flag bundle used by the
// coverage tracker and its modulo pipeline
// ---------------------------------------------------------------------------
`default_nettype none

package hbct_pkg;

  localparam int HASH_W    = 32;
  localparam int BYTE_W    = 8;
  localparam int FREQ_W    = 32;
  localparam int JUDG_W    = 8;
  localparam int OUT_W     = 8;

  // h*31 is built as (h << 5) - h
  localparam int HASH_SHIFT = 5;

  // bins marked per record
  localparam int SPREAD = 3;

  // judgment code that does not raise the negative flag
  localparam logic [JUDG_W-1:0] JUDG_EXEMPT = 8'd1;

  typedef struct packed {
    logic neg;
    logic pos;
  } rec_flags_t;

endpackage

`default_nettype wire

// ===== rtl/hashed_bin_coverage_tracker.sv =====
// ---------------------------------------------------------------------------
// hashed_bin_coverage_tracker: hashed bin coverage with sticky flags
// hashes identifier bytes per record, marks consecutive bins on record close
// and reports bin base, active bin count and sticky neg/pos/full flags
// ---------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_stall   | id_byte, byte_present, last, freq, judgment
//  out     | out_valid / out_stall | bin_base, active_bins, neg_flag, pos_flag,
//          |                       | full_flag
//
//  one request per cycle sustained while out_stall stays low; the hash step
//  is a shift-subtract-add. a closing request passes stage a (hash captured),
//  stage b (32x33 reciprocal multiply), stage c (constant multiply and
//  remainder fix-up), then bin marking into the result register
//  reset is synchronous; it clears hash, all bin hit bits, count, flags and
//  pipeline valids at once, no clearing pass
//  out_stall holds the result; the pipeline keeps filling until its first
//  stage is blocked, and only then in_stall rises
// ---------------------------------------------------------------------------
`default_nettype none

module hashed_bin_coverage_tracker #(
  parameter int NUM_BINS = 254
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [hbct_pkg::BYTE_W-1:0]  id_byte,
  input  wire logic                         byte_present,
  input  wire logic                         last,
  input  wire logic [hbct_pkg::FREQ_W-1:0]  freq,
  input  wire logic [hbct_pkg::JUDG_W-1:0]  judgment,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [hbct_pkg::OUT_W-1:0]        bin_base,
  output logic [hbct_pkg::OUT_W-1:0]        active_bins,
  output logic                              neg_flag,
  output logic                              pos_flag,
  output logic                              full_flag
);

  import hbct_pkg::*;

  localparam int IDX_W = $clog2(NUM_BINS);
  localparam int CNT_W = $clog2(NUM_BINS + 1);
  localparam logic [IDX_W:0] BINS_R = (IDX_W+1)'(NUM_BINS);
  localparam logic [CNT_W-1:0] BINS_C = CNT_W'(NUM_BINS);

  // running hash of the open record
  logic [HASH_W-1:0]   hash_acc;
  logic [HASH_W-1:0]   hash_step;
  logic [HASH_W-1:0]   hash_push;
  logic                in_accept;
  logic                push_valid;
  logic                mod_stall;
  rec_flags_t          push_flags;

  // modulo pipeline result
  logic                mod_valid;
  logic [IDX_W-1:0]    mod_rem;
  rec_flags_t          mod_flags;
  logic                take;

  // coverage state
  logic [NUM_BINS-1:0] bin_hit;
  logic [NUM_BINS-1:0] bin_hit_next;
  logic [CNT_W-1:0]    active_count;
  logic [CNT_W-1:0]    active_count_next;
  logic                neg_seen, pos_seen, full_seen;
  logic                neg_seen_next, pos_seen_next, full_seen_next;
  logic [IDX_W-1:0]    mark_idx [SPREAD];
  logic [SPREAD-1:0]   new_hit;
  logic [IDX_W-1:0]    base_reg;

  // ---- hashing -------------------------------------------------------------

  // h*31 + sign-extended byte, wrapping at 32 bits
  assign hash_step = (hash_acc << HASH_SHIFT) - hash_acc
                   + {{(HASH_W-BYTE_W){id_byte[BYTE_W-1]}}, id_byte};
  assign hash_push = byte_present ? hash_step : hash_acc;

  assign in_stall   = mod_stall;
  assign in_accept  = in_valid && !in_stall;
  // only closing requests travel on; the rest just fold into the hash
  assign push_valid = in_valid && last;
  assign push_flags = '{neg: (judgment != JUDG_EXEMPT), pos: (freq != '0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_acc <= '0;
    end else if (in_accept) begin
      if (last) begin
        hash_acc <= '0;
      end else if (byte_present) begin
        hash_acc <= hash_step;
      end
    end
  end

  // ---- h mod NUM_BINS ------------------------------------------------------

  hbct_binmod #(
    .NUM_BINS (NUM_BINS)
  ) u_binmod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_stall  (mod_stall),
    .in_hash   (hash_push),
    .in_flags  (push_flags),
    .out_valid (mod_valid),
    .out_take  (take),
    .out_rem   (mod_rem),
    .out_flags (mod_flags)
  );

  // ---- bin marking and flags -----------------------------------------------

  // result register is free, or being emptied this cycle
  assign take = mod_valid && (!out_valid || !out_stall);

  // consecutive bins from the base, wrapping around the bin count
  always_comb begin
    logic [IDX_W:0] sum;
    for (int k = 0; k < SPREAD; k++) begin
      sum = (IDX_W+1)'(mod_rem) + (IDX_W+1)'(k);
      if (sum >= BINS_R) begin
        sum = sum - BINS_R;
      end
      mark_idx[k] = sum[IDX_W-1:0];
      new_hit[k]  = !bin_hit[mark_idx[k]];
    end
  end

  // bins are distinct, so each newly hit one counts once
  always_comb begin
    bin_hit_next      = bin_hit;
    active_count_next = active_count;
    for (int k = 0; k < SPREAD; k++) begin
      bin_hit_next[mark_idx[k]] = 1'b1;
      active_count_next = active_count_next + CNT_W'(new_hit[k]);
    end
  end

  // full is judged after this record's flags and bins are in
  assign neg_seen_next  = neg_seen || mod_flags.neg;
  assign pos_seen_next  = pos_seen || mod_flags.pos;
  assign full_seen_next = full_seen
                       || (neg_seen_next && pos_seen_next
                           && (active_count_next >= BINS_C));

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_hit      <= '0;
      active_count <= '0;
      neg_seen     <= 1'b0;
      pos_seen     <= 1'b0;
      full_seen    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (take) begin
        bin_hit      <= bin_hit_next;
        active_count <= active_count_next;
        neg_seen     <= neg_seen_next;
        pos_seen     <= pos_seen_next;
        full_seen    <= full_seen_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      base_reg <= mod_rem;
    end
  end

  // state only moves on take, so it doubles as the held result
  assign bin_base    = OUT_W'(base_reg);
  assign active_bins = OUT_W'(active_count);
  assign neg_flag    = neg_seen;
  assign pos_flag    = pos_seen;
  assign full_flag   = full_seen;

`ifndef SYNTHESIS
  // count tracks the hit bits exactly
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(bin_hit) == active_count)
    else $error("active count differs from hit bits");

  // full only with both flags up and every bin hit
  a_full_cond: assert property (@(posedge clk) disable iff (rst)
    full_seen |-> (neg_seen && pos_seen && active_count == BINS_C))
    else $error("full flag without its conditions");

  // the sticky full flag never drops outside reset
  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    full_seen |=> full_seen)
    else $error("full flag cleared");

  // a taken remainder always lands in the result register in range
  a_take_result: assert property (@(posedge clk) disable iff (rst)
    take |=> (out_valid && (IDX_W+1)'(base_reg) < BINS_R))
    else $error("result missing or bin base out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/hbct_binmod.sv =====
// ---------------------------------------------------------------------------
// hbct_binmod: hash modulo bin count
// three-stage pipeline, reciprocal multiply, constant multiply and one
// corrective subtract; stages move independently so bubbles are squeezed out
// ---------------------------------------------------------------------------
`default_nettype none

module hbct_binmod #(
  parameter int NUM_BINS = 254
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [hbct_pkg::HASH_W-1:0]       in_hash,
  input  wire hbct_pkg::rec_flags_t              in_flags,
  output logic                                   out_valid,
  input  wire logic                              out_take,
  output logic [$clog2(NUM_BINS)-1:0]            out_rem,
  output hbct_pkg::rec_flags_t                   out_flags
);

  import hbct_pkg::*;

  localparam int IDX_W   = $clog2(NUM_BINS);
  localparam int SHIFT   = HASH_W + IDX_W;
  localparam int RECIP_W = HASH_W + 1;
  localparam int PROD_W  = HASH_W + RECIP_W;
  localparam int QUOT_W  = PROD_W - SHIFT;
  localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'(NUM_BINS);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
  localparam logic [IDX_W:0] BINS_R = (IDX_W+1)'(NUM_BINS);

  // stage a: hash captured
  logic              a_valid;
  logic [HASH_W-1:0] a_hash;
  rec_flags_t        a_flags;
  // stage b: quotient estimate, low by at most one
  logic              b_valid;
  logic [HASH_W-1:0] b_hash;
  logic [QUOT_W-1:0] b_quot;
  rec_flags_t        b_flags;
  // stage c: remainder
  logic              c_valid;
  logic [IDX_W-1:0]  c_rem;
  rec_flags_t        c_flags;

  logic              a_free, b_free, c_free;
  logic [PROD_W-1:0] prod;
  logic [HASH_W-1:0] quot_n;
  logic [IDX_W:0]    rem_raw;
  logic [IDX_W:0]    rem_fix;

  assign c_free = !c_valid || out_take;
  assign b_free = !b_valid || c_free;
  assign a_free = !a_valid || b_free;
  assign in_stall = !a_free;

  assign prod    = PROD_W'(a_hash) * PROD_W'(RECIP);
  assign quot_n  = HASH_W'(b_quot) * HASH_W'(NUM_BINS);
  assign rem_raw = (IDX_W+1)'(b_hash - quot_n);
  assign rem_fix = (rem_raw >= BINS_R) ? rem_raw - BINS_R : rem_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid <= in_valid;
      end
      if (b_free) begin
        b_valid <= a_valid;
      end
      if (c_free) begin
        c_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && in_valid) begin
      a_hash  <= in_hash;
      a_flags <= in_flags;
    end
    if (b_free && a_valid) begin
      b_hash  <= a_hash;
      b_quot  <= prod[PROD_W-1:SHIFT];
      b_flags <= a_flags;
    end
    if (c_free && b_valid) begin
      c_rem   <= rem_fix[IDX_W-1:0];
      c_flags <= b_flags;
    end
  end

  assign out_valid = c_valid;
  assign out_rem   = c_rem;
  assign out_flags = c_flags;

endmodule

`default_nettype wire
